// File: rtl/tckf_pkg.sv
// Shared constants, types and fixed-point helpers of the three-channel range filter.
package tckf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NCH       = 3;
    localparam int DATA_W    = 32;
    localparam int SMP_W     = 16;
    localparam int COV_W     = 31;
    localparam int NOISE_W   = 31;
    localparam int PVAR_W    = 17;
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(GAIN_W + 1);
    localparam int CH_W      = $clog2(NCH);
    localparam int CFG_IDX_W = 3;

    // shared multiplier operands: A carries 33-bit signed differences
    localparam int MA_W   = DATA_W + 1;
    localparam int MB_W   = ((GAIN_W > PVAR_W) ? GAIN_W : PVAR_W) + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int WIDE_W = PROD_W + 2;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    localparam t_wide WIDE_MAX = t_wide'(64'sd2147483647);
    localparam t_wide WIDE_MIN = ~WIDE_MAX;
    localparam t_wide HALF     = t_wide'(64'sd1 << (FRAC_BITS - 1));

    localparam logic [GAIN_W-1:0] GAIN_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COV_W-1:0]  COV_RESET = COV_W'(64'd2 << FRAC_BITS);

    // register map
    localparam t_cfg_idx CFG_SCALE_RIGHT  = 3'd0;
    localparam t_cfg_idx CFG_SCALE_LEFT   = 3'd1;
    localparam t_cfg_idx CFG_SCALE_PITCH  = 3'd2;
    localparam t_cfg_idx CFG_OFFSET_RIGHT = 3'd3;
    localparam t_cfg_idx CFG_OFFSET_LEFT  = 3'd4;
    localparam t_cfg_idx CFG_OFFSET_PITCH = 3'd5;
    localparam t_cfg_idx CFG_MEAS_NOISE   = 3'd6;
    localparam t_cfg_idx CFG_PROCESS_VAR  = 3'd7;

    localparam logic signed [DATA_W-1:0] RST_SCALE_RIGHT  = 32'sd46981;
    localparam logic signed [DATA_W-1:0] RST_SCALE_LEFT   = 32'sd46799;
    localparam logic signed [DATA_W-1:0] RST_SCALE_PITCH  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_OFFSET_RIGHT = 32'sd9251400;
    localparam logic signed [DATA_W-1:0] RST_OFFSET_LEFT  = 32'sd9518407;
    localparam logic signed [DATA_W-1:0] RST_OFFSET_PITCH = 32'sd0;
    localparam logic [NOISE_W-1:0]       RST_MEAS_NOISE   = 31'd131072;
    localparam logic [PVAR_W-1:0]        RST_PROCESS_VAR  = 17'd59;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [COV_W-1:0] p;
        logic [NOISE_W-1:0] r;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] gain;
    } t_div_rsp;

    function automatic logic signed [DATA_W-1:0] sat_s32(input t_wide v);
        logic signed [DATA_W-1:0] res;
        if (v > WIDE_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < WIDE_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // divide by 2^FRAC_BITS, nearest, halves towards plus infinity
    function automatic t_wide rnd_s(input t_wide v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

endpackage

// File: rtl/tckf_in_if.sv
// Input channel: three converter samples per item.
interface tckf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_right;
    logic [15:0] sample_left;
    logic [15:0] sample_pitch;

    modport source (output valid, output sample_right, output sample_left,
                    output sample_pitch, input ready);
    modport sink   (input valid, input sample_right, input sample_left,
                    input sample_pitch, output ready);
endinterface

// File: rtl/tckf_out_if.sv
// Output channel: three filtered distances per item.
interface tckf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] distance_right;
    logic signed [31:0] distance_left;
    logic signed [31:0] distance_pitch;

    modport source (output valid, output distance_right, output distance_left,
                    output distance_pitch, input ready);
    modport sink   (input valid, input distance_right, input distance_left,
                    input distance_pitch, output ready);
endinterface

// File: rtl/three_channel_range_kalman_filter.sv
// Top level of the three-channel range filter: sequencer, state and configuration.
//
// Usage
//   i_smp carries one item of three unsigned converter samples (right, left,
//   pitch). Each sample is mapped to a distance, raw = scale*sample + offset,
//   and then smoothed by a scalar adaptive Kalman step kept per channel.
//   o_dist carries one item of three filtered Q16.16 distances per input item.
//   The register port (i_cfg_we, i_cfg_idx, i_cfg_data) sets scales, offsets,
//   R and Q; write it only while the block is idle.
// Timing
//   Channels are worked in turn through one shared multiplier and one
//   bit-serial divider, which forms each gain in FRAC_BITS + 1 quotient steps.
//   After the last channel the estimates are loaded into the result register
//   and shown on o_dist; ready is high only in idle, so an item is accepted
//   only once the previous one has been worked through.
// Reset and stall
//   Reset loads the default registers, zero estimates, a covariance of 2.0 on
//   every channel and an empty o_dist. A result waits on o_dist until taken
//   while the next item is worked, which holds at its end until o_dist is free.
module three_channel_range_kalman_filter
    import tckf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]   i_cfg_data,
    tckf_in_if.sink             i_smp,
    tckf_out_if.source          o_dist
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_RAW  = 10'b0000000010,
        ST_SUM  = 10'b0000000100,
        ST_DIVW = 10'b0000001000,
        ST_STEP = 10'b0000010000,
        ST_UPD  = 10'b0000100000,
        ST_ACC  = 10'b0001000000,
        ST_QMUL = 10'b0010000000,
        ST_PNEW = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [CH_W-1:0] r_ch;

    // configuration
    logic signed [DATA_W-1:0] r_scale  [NCH];
    logic signed [DATA_W-1:0] r_offset [NCH];
    logic [NOISE_W-1:0]       r_noise;
    logic [PVAR_W-1:0]        r_pvar;

    // filter state per channel
    logic signed [DATA_W-1:0] r_est [NCH];
    logic [COV_W-1:0]         r_cov [NCH];

    // item payload and working registers
    logic [SMP_W-1:0]         r_smp  [NCH];
    logic signed [DATA_W-1:0] r_dist [NCH];
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_raw;
    logic signed [DATA_W-1:0] r_upd;
    logic [COV_W-1:0]         r_acc;
    logic [DATA_W-1:0]        r_chg;

    // shared units
    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    logic signed [DATA_W-1:0] w_old;
    logic [COV_W-1:0]         w_p;
    t_wide                    w_prod_x;
    t_wide                    w_prod_rnd;
    t_wide                    w_raw_sum;
    t_wide                    w_upd_sum;
    t_wide                    w_np;
    logic signed [DATA_W:0]   w_dchg;
    logic [DATA_W:0]          w_dchg_abs;
    logic [COV_W-1:0]         w_np_sat;
    logic                     w_last_ch;
    logic                     w_out_load;

    tckf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    tckf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_old     = r_est[r_ch];
    assign w_p       = r_cov[r_ch];
    assign w_last_ch = (r_ch == CH_W'(NCH - 1));

    // result register takes the new estimates once empty or being taken now
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || o_dist.ready);

    // gain = P / (P + R) runs while the raw distance is formed
    assign w_div_req.start = (r_state == ST_RAW);
    assign w_div_req.p     = w_p;
    assign w_div_req.r     = r_noise;

    // multiplier operand selection by step
    always_comb begin
        case (r_state)
            ST_RAW: begin
                w_mul_a = {r_scale[r_ch][DATA_W-1], r_scale[r_ch]};
                w_mul_b = {{(MB_W-SMP_W){1'b0}}, r_smp[r_ch]};
            end
            ST_STEP: begin
                w_mul_a = {r_raw[DATA_W-1], r_raw} - {w_old[DATA_W-1], w_old};
                w_mul_b = {{(MB_W-GAIN_W){1'b0}}, w_div_rsp.gain};
            end
            ST_UPD: begin
                w_mul_a = {{(MA_W-COV_W){1'b0}}, w_p};
                w_mul_b = {{(MB_W-GAIN_W){1'b0}}, GAIN_ONE - w_div_rsp.gain};
            end
            ST_QMUL: begin
                w_mul_a = {1'b0, r_chg};
                w_mul_b = {{(MB_W-PVAR_W){1'b0}}, r_pvar};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod_x   = t_wide'(w_prod);
    assign w_prod_rnd = rnd_s(w_prod_x);
    assign w_raw_sum  = w_prod_x + t_wide'(r_offset[r_ch]);
    assign w_upd_sum  = w_prod_rnd + t_wide'(w_old);

    // |change| of the stored estimate
    assign w_dchg     = {r_upd[DATA_W-1], r_upd} - {w_old[DATA_W-1], w_old};
    assign w_dchg_abs = w_dchg[DATA_W] ? (DATA_W+1)'(-w_dchg) : w_dchg;

    // new covariance, both terms non-negative
    assign w_np     = w_prod_rnd + t_wide'({1'b0, r_acc});
    assign w_np_sat = (w_np > WIDE_MAX) ? {COV_W{1'b1}} : w_np[COV_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_smp.valid) n_state = ST_RAW;
            ST_RAW:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_DIVW;
            ST_DIVW: if (w_div_rsp.done) n_state = ST_STEP;
            ST_STEP: n_state = ST_UPD;
            ST_UPD:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_QMUL;
            ST_QMUL: n_state = ST_PNEW;
            ST_PNEW: n_state = w_last_ch ? ST_OUT : ST_RAW;
            ST_OUT:  if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_ch <= '0;
            end else if (r_state == ST_PNEW && !w_last_ch) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // register writes; the map covers every 3-bit index, so each index matches an arm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale[0]  <= RST_SCALE_RIGHT;
            r_scale[1]  <= RST_SCALE_LEFT;
            r_scale[2]  <= RST_SCALE_PITCH;
            r_offset[0] <= RST_OFFSET_RIGHT;
            r_offset[1] <= RST_OFFSET_LEFT;
            r_offset[2] <= RST_OFFSET_PITCH;
            r_noise     <= RST_MEAS_NOISE;
            r_pvar      <= RST_PROCESS_VAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE_RIGHT:  r_scale[0]  <= i_cfg_data;
                CFG_SCALE_LEFT:   r_scale[1]  <= i_cfg_data;
                CFG_SCALE_PITCH:  r_scale[2]  <= i_cfg_data;
                CFG_OFFSET_RIGHT: r_offset[0] <= i_cfg_data;
                CFG_OFFSET_LEFT:  r_offset[1] <= i_cfg_data;
                CFG_OFFSET_PITCH: r_offset[2] <= i_cfg_data;
                CFG_MEAS_NOISE:   r_noise     <= i_cfg_data[NOISE_W-1:0];
                CFG_PROCESS_VAR:  r_pvar      <= i_cfg_data[PVAR_W-1:0];
                default: ;
            endcase
        end
    end

    // estimate and covariance commit at the end of each channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_est[i] <= '0;
                r_cov[i] <= COV_RESET;
            end
        end else if (r_state == ST_PNEW) begin
            r_est[r_ch] <= r_upd;
            r_cov[r_ch] <= w_np_sat;
        end
    end

    // output item held until taken; a fresh load wins over a take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_dist.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_smp.valid) begin
            r_smp[0] <= i_smp.sample_right;
            r_smp[1] <= i_smp.sample_left;
            r_smp[2] <= i_smp.sample_pitch;
        end
        if (r_state == ST_SUM) begin
            r_raw <= sat_s32(w_raw_sum);
        end
        if (r_state == ST_UPD) begin
            r_upd <= sat_s32(w_upd_sum);
        end
        if (r_state == ST_ACC) begin
            r_acc <= w_prod_rnd[COV_W-1:0];
            r_chg <= w_dchg_abs[DATA_W-1:0];
        end
        if (w_out_load) begin
            for (int i = 0; i < NCH; i++) begin
                r_dist[i] <= r_est[i];
            end
        end
    end

    assign i_smp.ready           = (r_state == ST_IDLE);
    assign o_dist.valid          = r_out_valid;
    assign o_dist.distance_right = r_dist[0];
    assign o_dist.distance_left  = r_dist[1];
    assign o_dist.distance_pitch = r_dist[2];

endmodule

// File: rtl/tckf_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle.
module tckf_div
    import tckf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DATA_W-1:0] r_den;
    logic [DATA_W-1:0] r_rem;
    logic              r_shin;
    logic [GAIN_W-1:0] r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0] w_trial;
    logic [DATA_W:0] w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_shin};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(GAIN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // dividend is p << FRAC_BITS: start from p >> 1, then shift in p[0] and zeros
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= DATA_W'(i_req.p) + DATA_W'(i_req.r);
            r_rem  <= {2'b00, i_req.p[COV_W-1:1]};
            r_shin <= i_req.p[0];
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_shin <= 1'b0;
            r_q    <= {r_q[GAIN_W-2:0], w_ge};
        end
    end

    // zero denominator gives zero gain
    assign o_rsp.done = r_done;
    assign o_rsp.gain = (r_den == '0) ? '0 : r_q;

endmodule

// File: rtl/tckf_mul.sv
// Shared signed multiplier with registered product.
module tckf_mul
    import tckf_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: tb/range_filter_checker.sv
// Passive checker: mirrors the filter state, predicts each output item and compares it.
module range_filter_checker
    import tckf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    tckf_in_if                   i_smp,
    tckf_out_if                  i_dist,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q     = longint'(1) << (FRAC_BITS - 1);
    localparam longint S32_HI     = 64'sd2147483647;
    localparam longint S32_LO     = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] right;
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] pitch;
    } t_range_item;

    logic signed [DATA_W-1:0] scale_q  [NCH];
    logic signed [DATA_W-1:0] offset_q [NCH];
    logic [NOISE_W-1:0]       noise_q;
    logic [PVAR_W-1:0]        pvar_q;
    logic signed [DATA_W-1:0] est_q    [NCH];
    logic [COV_W-1:0]         cov_q    [NCH];
    t_range_item              dist_expected [$];
    int                       mismatches = 0;

    function automatic longint clip_s32(input longint v);
        if (v > S32_HI) return S32_HI;
        if (v < S32_LO) return S32_LO;
        return v;
    endfunction

    // one Kalman step on one channel; updates the mirrored estimate and covariance
    function automatic logic signed [DATA_W-1:0] smooth_channel(input int ch,
                                                               input logic [SMP_W-1:0] smp);
        longint raw, p, den, gain, prev, upd, change, p_next;
        raw    = clip_s32(longint'(scale_q[ch]) * longint'(smp) + longint'(offset_q[ch]));
        p      = longint'(cov_q[ch]);
        den    = p + longint'(noise_q);
        gain   = (den != 0) ? (p << FRAC_BITS) / den : 0;
        if (gain > ONE_Q) gain = ONE_Q;
        prev   = longint'(est_q[ch]);
        upd    = clip_s32(prev + ((gain * (raw - prev) + HALF_Q) >>> FRAC_BITS));
        change = (upd >= prev) ? upd - prev : prev - upd;
        p_next = (((ONE_Q - gain) * p + HALF_Q) >>> FRAC_BITS)
               + ((change * longint'(pvar_q) + HALF_Q) >>> FRAC_BITS);
        if (p_next > S32_HI) p_next = S32_HI;
        est_q[ch] = upd[DATA_W-1:0];
        cov_q[ch] = p_next[COV_W-1:0];
        return upd[DATA_W-1:0];
    endfunction

    task automatic flag(input string msg);
        mismatches++;
        $error("%s", msg);
    endtask

    task automatic check_field(input string field, input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
        if (got !== want) begin
            flag($sformatf("%s: expected %0d, got %0d", field, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        t_range_item want;
        t_range_item got;
        if (!i_rst_n) begin
            scale_q[0]  = RST_SCALE_RIGHT;
            scale_q[1]  = RST_SCALE_LEFT;
            scale_q[2]  = RST_SCALE_PITCH;
            offset_q[0] = RST_OFFSET_RIGHT;
            offset_q[1] = RST_OFFSET_LEFT;
            offset_q[2] = RST_OFFSET_PITCH;
            noise_q     = RST_MEAS_NOISE;
            pvar_q      = RST_PROCESS_VAR;
            for (int ch = 0; ch < NCH; ch++) begin
                est_q[ch] = '0;
                cov_q[ch] = COV_W'(64'd2 << FRAC_BITS);
            end
            dist_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCALE_RIGHT:  scale_q[0]  = i_cfg_data;
                    CFG_SCALE_LEFT:   scale_q[1]  = i_cfg_data;
                    CFG_SCALE_PITCH:  scale_q[2]  = i_cfg_data;
                    CFG_OFFSET_RIGHT: offset_q[0] = i_cfg_data;
                    CFG_OFFSET_LEFT:  offset_q[1] = i_cfg_data;
                    CFG_OFFSET_PITCH: offset_q[2] = i_cfg_data;
                    CFG_MEAS_NOISE:   noise_q     = i_cfg_data[NOISE_W-1:0];
                    CFG_PROCESS_VAR:  pvar_q      = i_cfg_data[PVAR_W-1:0];
                    default: ;
                endcase
            end
            if (i_dist.valid && i_dist.ready) begin
                got = {i_dist.distance_right, i_dist.distance_left, i_dist.distance_pitch};
                if (dist_expected.size() == 0) begin
                    flag($sformatf("output item %0d/%0d/%0d with no input item pending",
                                   got.right, got.left, got.pitch));
                end else begin
                    want = dist_expected.pop_front();
                    check_field("distance_right", want.right, got.right);
                    check_field("distance_left",  want.left,  got.left);
                    check_field("distance_pitch", want.pitch, got.pitch);
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                want.right = smooth_channel(0, i_smp.sample_right);
                want.left  = smooth_channel(1, i_smp.sample_left);
                want.pitch = smooth_channel(2, i_smp.sample_pitch);
                dist_expected.push_back(want);
            end
        end
        o_errors  <= mismatches;
        o_pending <= dist_expected.size();
    end

endmodule

// File: tb/three_channel_range_kalman_filter_tb.sv
// Stimulus and verdict for the three-channel range filter; checking is in range_filter_checker.
module three_channel_range_kalman_filter_tb import tckf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // pacing changes over the run: receiver lazy first, then sender, then flat out
    localparam int PACE_SWAP_AT  = 480;
    localparam int PACE_FREE_AT  = 960;
    localparam int RAND_PHASES   = 13;
    localparam int PHASE_ITEMS   = 108;
    localparam int DRAIN_SLACK   = 100;   // > one item's latency
    localparam int NUM_REGS      = 8;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [DATA_W-1:0]    cfg_data   = '0;
    logic                 smp_valid  = 1'b0;
    logic [SMP_W-1:0]     smp_right  = '0;
    logic [SMP_W-1:0]     smp_left   = '0;
    logic [SMP_W-1:0]     smp_pitch  = '0;
    logic                 dist_ready = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int settings_used = 0;
    int errors;
    int pending;

    // register values for the next setting, indexed by register code
    logic [DATA_W-1:0] reg_plan [NUM_REGS];
    // slowly moving level per channel, so most samples look like a real sensor
    logic [SMP_W-1:0]  walk [NCH] = '{16'd20000, 16'd30000, 16'd40000};

    tckf_in_if  smp_if ();
    tckf_out_if dist_if ();

    assign smp_if.valid        = smp_valid;
    assign smp_if.sample_right = smp_right;
    assign smp_if.sample_left  = smp_left;
    assign smp_if.sample_pitch = smp_pitch;
    assign dist_if.ready       = dist_ready;

    three_channel_range_kalman_filter uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_if.sink),
        .o_dist     (dist_if.source)
    );

    range_filter_checker u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_if),
        .i_dist     (dist_if),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // receiver: ready drops at random with the current stall percentage
    always @(posedge clk) begin
        if (!rst_n) begin
            dist_ready <= 1'b0;
        end else begin
            dist_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offers one item after an optional random gap and holds it until taken;
    // valid is only lowered on the gap path, so it is never dropped and raised in one step
    task automatic send_item(input logic [SMP_W-1:0] r, input logic [SMP_W-1:0] l,
                             input logic [SMP_W-1:0] p);
        if (items_sent < PACE_SWAP_AT) begin
            send_idle_pct = 30;
            recv_idle_pct = 86;
        end else if (items_sent < PACE_FREE_AT) begin
            send_idle_pct = 86;
            recv_idle_pct = 30;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            smp_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        smp_valid <= 1'b1;
        smp_right <= r;
        smp_left  <= l;
        smp_pitch <= p;
        do @(posedge clk); while (!smp_if.ready);
        items_sent++;
    endtask

    // holds the sender off until every predicted item has come out;
    // the checker's count is registered, hence the edge before the first look
    task automatic wait_drained();
        smp_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // writes all eight registers from reg_plan once the block is idle
    task automatic program_regs();
        wait_drained();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(i);
            cfg_data <= reg_plan[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random register value: mostly usable filter settings, sometimes the extremes
    function automatic logic [DATA_W-1:0] pick_reg(input t_cfg_idx idx);
        int roll;
        roll = $urandom_range(99);
        case (idx)
            CFG_SCALE_RIGHT, CFG_SCALE_LEFT, CFG_SCALE_PITCH: begin
                if (roll < 4) return 32'h7FFF_FFFF;
                if (roll < 8) return 32'h8000_0000;
                if (roll < 11) return '0;
                if (roll < 21) return $urandom;
                return DATA_W'(int'($urandom_range(0, 262144)) - 131072);
            end
            CFG_OFFSET_RIGHT, CFG_OFFSET_LEFT, CFG_OFFSET_PITCH: begin
                if (roll < 4) return 32'h7FFF_FFFF;
                if (roll < 8) return 32'h8000_0000;
                if (roll < 18) return $urandom;
                return DATA_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            end
            CFG_MEAS_NOISE: begin
                // never zero here: zero noise can freeze a channel for good
                if (roll < 8) return 32'd1;
                if (roll < 14) return 32'h7FFF_FFFF;
                if (roll < 20) return {1'b1, 31'($urandom_range(1, 1 << 20))};
                return DATA_W'($urandom_range(1, 1 << $urandom_range(1, 26)));
            end
            CFG_PROCESS_VAR: begin
                if (roll < 8) return '0;
                if (roll < 14) return 32'd65536;
                if (roll < 18) return 32'd131071;        // Q above 1.0
                if (roll < 24) return $urandom;          // upper bits fall away
                return DATA_W'($urandom_range(0, 1 << $urandom_range(0, 16)));
            end
            default: return '0;
        endcase
    endfunction

    // sample source: a random walk, step changes, lone outliers and bit patterns
    function automatic logic [SMP_W-1:0] next_sample(input int ch);
        int roll;
        int span;
        int v;
        roll = $urandom_range(99);
        if (roll < 60) begin
            span = 1 << $urandom_range(0, 10);
            v = int'(walk[ch]) + int'($urandom_range(0, 2 * span)) - span;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            walk[ch] = SMP_W'(v);
            return walk[ch];
        end
        if (roll < 85) begin
            walk[ch] = SMP_W'($urandom);
            return walk[ch];
        end
        if (roll < 93) return SMP_W'($urandom);
        case ($urandom_range(3))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'h5555;
            default: return 16'hAAAA;
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: extremes of the samples, alternating bits, a steady input
        send_item(16'h0000, 16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'h0000, 16'h0000, 16'h0000);
        send_item(16'h5555, 16'hAAAA, 16'h8000);
        send_item(16'hAAAA, 16'h5555, 16'h7FFF);
        send_item(16'd1000, 16'd2000, 16'd3000);
        send_item(16'd1000, 16'd2000, 16'd3000);
        send_item(16'd1000, 16'd2000, 16'd3000);
        send_item(16'hFFFF, 16'h0000, 16'h8000);
        send_item(16'h0000, 16'hFFFF, 16'h0001);

        // raw distance saturating high on the right and low on the left, tiny R,
        // Q above 1.0 so large swings push the covariance into saturation
        reg_plan[CFG_SCALE_RIGHT]  = 32'h7FFF_FFFF;
        reg_plan[CFG_SCALE_LEFT]   = 32'h8000_0000;
        reg_plan[CFG_SCALE_PITCH]  = 32'h0001_0000;
        reg_plan[CFG_OFFSET_RIGHT] = 32'h7FFF_FFFF;
        reg_plan[CFG_OFFSET_LEFT]  = 32'h8000_0000;
        reg_plan[CFG_OFFSET_PITCH] = 32'h8000_0000;
        reg_plan[CFG_MEAS_NOISE]   = 32'd1;
        reg_plan[CFG_PROCESS_VAR]  = 32'd131071;
        program_regs();
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'h0000, 16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'h0000, 16'hFFFF, 16'h0000);
        send_item(16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(16'h0001, 16'h0001, 16'h0001);

        // random settings, each followed by a run of sensor-like items;
        // now and then the sender waits for the pipeline to empty
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                reg_plan[i] = pick_reg(t_cfg_idx'(i));
            end
            program_regs();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) == 0) wait_drained();
                send_item(next_sample(0), next_sample(1), next_sample(2));
            end
        end

        // zero noise last: gain is exactly one while the covariance is non-zero,
        // and once it hits zero the gain is taken as zero for good
        reg_plan[CFG_MEAS_NOISE] = '0;
        program_regs();
        for (int n = 0; n < 15; n++) begin
            send_item(next_sample(0), next_sample(1), next_sample(2));
        end
        reg_plan[CFG_PROCESS_VAR] = '0;
        program_regs();
        send_item(16'd100,  16'd200,  16'd300);
        send_item(16'd100,  16'd200,  16'd300);
        send_item(16'd5000, 16'd6000, 16'd7000);

        wait_drained();
        repeat (DRAIN_SLACK) @(posedge clk);
        $display("Run covered %0d input items under %0d register settings,",
                 items_sent, settings_used);
        $display("with saturating scales and offsets, zero noise and stalls on both sides.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
